@@ hdl/tlsg_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsg_pkg
// Shared types and constants for the trapezoid line step generator.
// ----------------------------------------------------------------------------
package tlsg_pkg;

    localparam int FEED_W = 40;
    localparam int DIV_W  = 48;

    typedef enum logic [2:0] {
        ST_STEP     = 3'd0,
        ST_FINISHED = 3'd1,
        ST_ABORT    = 3'd2,
        ST_REJECTED = 3'd3,
        ST_IDLE     = 3'd4,
        ST_STARTED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_STOP   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_DECODE,
        FS_DIV1,
        FS_WAIT1,
        FS_FDIV,
        FS_WAITF,
        FS_DIV2,
        FS_WAIT2,
        FS_MUL,
        FS_FEED,
        FS_OUT
    } fsm_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic decode;
        logic div_k;
        logic div_feed;
        logic feed_hi;
        logic div_delay;
        logic mul_dv;
        logic feed_upd;
        logic emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_tick;
        logic tick_done;
        logic div_busy;
    } stat_t;

endpackage

@@ hdl/tlsg_divider.sv @@
// ----------------------------------------------------------------------------
// tlsg_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlsg_divider
    import tlsg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]   trial;

    // one shift-subtract step
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dsr_reg};
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CNT_W'(DIV_W);
        end else if (cnt_reg != '0) begin
            if (!trial[DIV_W]) begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

@@ hdl/tlsg_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlsg_ctrl
// Sequencer for one item: decode, then for a stepping tick the divisions and feed update, then output.
// ----------------------------------------------------------------------------
module tlsg_ctrl
    import tlsg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_fire,
    input  logic  out_free,
    input  stat_t stat,
    output logic  in_ready,
    output cmd_t  cmd
);

    fsm_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            FS_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load_item = 1'b1;
                    state_next    = FS_DECODE;
                end
            end
            FS_DECODE: begin
                cmd.decode = 1'b1;
                if (stat.is_tick && stat.tick_done) state_next = FS_DIV1;
                else state_next = FS_OUT;
            end
            FS_DIV1: begin
                cmd.div_k  = 1'b1;
                state_next = FS_WAIT1;
            end
            FS_WAIT1: if (!stat.div_busy) state_next = FS_FDIV;
            // feed scaled down by reciprocal multiply, low then high half
            FS_FDIV: begin
                cmd.div_feed = 1'b1;
                state_next   = FS_WAITF;
            end
            FS_WAITF: begin
                cmd.feed_hi = 1'b1;
                state_next  = FS_DIV2;
            end
            FS_DIV2: begin
                cmd.div_delay = 1'b1;
                state_next    = FS_WAIT2;
            end
            FS_WAIT2: if (!stat.div_busy) state_next = FS_MUL;
            FS_MUL: begin
                cmd.mul_dv = 1'b1;
                state_next = FS_FEED;
            end
            FS_FEED: begin
                cmd.feed_upd = 1'b1;
                state_next   = FS_OUT;
            end
            FS_OUT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = FS_IDLE;
                end
            end
            default: state_next = FS_IDLE;
        endcase
    end

    ap_load_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item |-> state_reg == FS_IDLE) else $error("load outside idle");
    ap_decode_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item |=> cmd.decode) else $error("decode missing");
    ap_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free) else $error("emit while output full");

endmodule

@@ hdl/tlsg_datapath.sv @@
// ----------------------------------------------------------------------------
// tlsg_datapath
// Move state, Bresenham stepping, feed profile and delay arithmetic.
// ----------------------------------------------------------------------------
module tlsg_datapath
    import tlsg_pkg::*;
#(
    parameter int AXES      = 3,
    parameter int STEP_BITS = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cmd_t          cmd,
    output stat_t         stat,
    input  logic [16:0]   accel_rate,
    input  logic          in_opcode,
    input  logic [AXES*STEP_BITS-1:0] in_steps,
    input  logic [23:0]   in_path_length,
    input  logic [15:0]   in_cruise_feed,
    input  logic [15:0]   in_feed_start,
    input  logic [15:0]   in_feed_stop,
    input  logic [23:0]   in_ramp_up,
    input  logic [23:0]   in_ramp_down,
    input  logic [2:0]    in_endstops,
    output logic [2:0]    res_status,
    output logic [2:0]    res_pulses,
    output logic [2:0]    res_dir,
    output logic [31:0]   res_delay
);

    localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int NAX  = (AXES < 3) ? AXES : 3;
    localparam logic [FEED_W-1:0] FEED_CEIL = '1;
    // ceil(2^44 / 125): exact floor(y / 125) for y below 2^37
    localparam logic [37:0] RECIP_125 = 38'd140737488356;

    // latched item
    logic                        op_reg;
    logic [AXES*STEP_BITS-1:0]   stp_reg;
    logic [23:0]                 len_in_reg, up_in_reg, dn_in_reg;
    logic [15:0]                 fs_in_reg, fe_in_reg, fc_in_reg;
    logic [2:0]                  es_reg;

    // move state
    phase_t                      phase_reg;
    logic                        moving_reg;
    logic [STEP_BITS-1:0]        count_reg, total_reg;
    logic [AX_W-1:0]             major_reg;
    logic [STEP_BITS-1:0]        mag_reg [AXES];
    logic [AXES-1:0]             neg_reg;
    logic [31:0]                 err_reg [AXES];
    logic [FEED_W-1:0]           feed_reg, floor_reg;
    logic [15:0]                 cruise_reg;
    logic [23:0]                 len_reg, up_reg, down_reg;
    logic [2:0]                  last_es_reg;

    // result and arithmetic
    logic [2:0]                  status_reg, pulses_reg;
    logic [31:0]                 delay_reg;
    logic [DIV_W-1:0]            k_reg, f_reg;
    logic [DIV_W+16:0]           dv_reg;
    logic                        tick_ok_reg;
    logic [56:0]                 plo_reg;

    logic             div_start, div_busy;
    logic [DIV_W-1:0] div_a, div_b, div_q;

    tlsg_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .busy(div_busy), .quotient(div_q)
    );

    // divider operand select
    always_comb begin
        div_start = cmd.div_k | cmd.div_delay;
        div_a = DIV_W'(len_reg) * DIV_W'(100);
        div_b = DIV_W'(total_reg);
        if (cmd.div_delay) begin
            div_a = k_reg * DIV_W'(6000);
            div_b = f_reg;
        end
    end

    // feed / 1000 as (feed >> 3) / 125 by reciprocal, high half product
    logic [55:0] recip_hi;
    logic [74:0] recip_sum;
    logic [30:0] feed_q;
    assign recip_hi  = 56'(feed_reg[39:22]) * 56'(RECIP_125);
    assign recip_sum = {recip_hi, 19'd0} + 75'(plo_reg);
    assign feed_q    = recip_sum[74:44];

    // start decode
    logic [STEP_BITS-1:0]  s_mag [AXES];
    logic [AXES-1:0]       s_neg;
    logic                  s_reject;
    logic [AX_W-1:0]       s_mi;
    logic [STEP_BITS-1:0]  s_best;
    logic [STEP_BITS-1:0]  sv;
    always_comb begin
        s_reject = 1'b0;
        for (int i = 0; i < AXES; i++) begin
            sv = stp_reg[i*STEP_BITS +: STEP_BITS];
            s_neg[i] = (i < 3) ? sv[STEP_BITS-1] : 1'b0;
            s_mag[i] = (i < 3) ? (sv[STEP_BITS-1] ? -sv : sv) : '0;
            if (i < 3 && es_reg[i] && s_neg[i]) s_reject = 1'b1;
        end
        s_mi = '0;
        s_best = s_mag[0];
        for (int i = 1; i < AXES; i++) begin
            if (s_mag[i] > s_best) begin
                s_best = s_mag[i];
                s_mi   = AX_W'(i);
            end
        end
    end

    // tick decode
    logic                  t_hit;
    logic [2:0]            t_pulses;
    logic [31:0]           t_err [AXES];
    logic [STEP_BITS-1:0]  t_cnt;
    logic [32:0]           t_twice;
    always_comb begin
        t_hit = 1'b0;
        t_pulses = '0;
        for (int i = 0; i < NAX; i++)
            if (neg_reg[i] && es_reg[i] && !last_es_reg[i]) t_hit = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            t_err[i] = err_reg[i];
            t_twice  = '0;
            if (AX_W'(i) == major_reg) begin
                if (i < 3) t_pulses[i] = 1'b1;
            end else begin
                t_err[i] = err_reg[i] + 32'(mag_reg[i]);
                t_twice  = {t_err[i], 1'b0};
                if ($signed(t_twice) >= $signed({1'b0, 32'(total_reg)})) begin
                    t_err[i] = t_err[i] - 32'(total_reg);
                    if (i < 3) t_pulses[i] = 1'b1;
                end
            end
        end
        t_cnt = count_reg + 1'b1;
    end

    logic moving_tick;
    assign moving_tick = moving_reg && (count_reg < total_reg);

    // feed update math
    logic [STEP_BITS:0]  cruise_end;
    logic [FEED_W:0]     f_up;
    logic [FEED_W-1:0]   dv_feed;
    logic                dv_big;
    logic [FEED_W:0]     f_dn;
    assign cruise_end = {1'b0, total_reg} - (STEP_BITS+1)'(down_reg);
    assign dv_big  = |dv_reg[DIV_W+16:FEED_W+4];
    assign dv_feed = dv_reg[FEED_W+3:4];
    assign f_up    = {1'b0, feed_reg} + {1'b0, dv_feed};
    assign f_dn    = {1'b0, feed_reg} - {1'b0, dv_feed};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_STOP;
            moving_reg  <= 1'b0;
            count_reg   <= '0;
            total_reg   <= '0;
            major_reg   <= '0;
            neg_reg     <= '0;
            feed_reg    <= '0;
            floor_reg   <= '0;
            cruise_reg  <= '0;
            len_reg     <= '0;
            up_reg      <= '0;
            down_reg    <= '0;
            last_es_reg <= '0;
            for (int i = 0; i < AXES; i++) begin
                mag_reg[i] <= '0;
                err_reg[i] <= '0;
            end
        end else begin
            if (cmd.decode) begin
                if (!op_reg) begin
                    neg_reg     <= s_neg;
                    last_es_reg <= es_reg;
                    for (int i = 0; i < AXES; i++) mag_reg[i] <= s_mag[i];
                    if (!s_reject) begin
                        major_reg  <= s_mi;
                        total_reg  <= s_best;
                        len_reg    <= len_in_reg;
                        cruise_reg <= fc_in_reg;
                        feed_reg   <= FEED_W'(fs_in_reg) * FEED_W'(1000);
                        floor_reg  <= FEED_W'(fe_in_reg) * FEED_W'(1000);
                        up_reg     <= up_in_reg;
                        down_reg   <= dn_in_reg;
                        if (s_best == '0) begin
                            moving_reg <= 1'b0;
                        end else begin
                            phase_reg  <= PH_ACCEL;
                            moving_reg <= 1'b1;
                            count_reg  <= '0;
                        end
                    end
                end else if (moving_tick) begin
                    if (t_hit) begin
                        moving_reg <= 1'b0;
                    end else begin
                        last_es_reg <= es_reg;
                        for (int i = 0; i < AXES; i++) err_reg[i] <= t_err[i];
                        count_reg <= t_cnt;
                        if (t_cnt >= total_reg) moving_reg <= 1'b0;
                    end
                end
            end
            // feed profile after delay is known
            if (cmd.feed_upd) begin
                case (phase_reg)
                    PH_ACCEL: begin
                        if ({1'b0, count_reg} >= (STEP_BITS+1)'(up_reg)) begin
                            if ($signed({1'b0, count_reg}) < $signed(cruise_end)) begin
                                phase_reg <= PH_CRUISE;
                                feed_reg  <= FEED_W'(cruise_reg) * FEED_W'(1000);
                            end else begin
                                phase_reg <= PH_DECEL;
                            end
                        end else if (dv_big || f_up[FEED_W]) begin
                            feed_reg <= FEED_CEIL;
                        end else begin
                            feed_reg <= f_up[FEED_W-1:0];
                        end
                    end
                    PH_CRUISE: begin
                        if ($signed({1'b0, count_reg}) >= $signed(cruise_end))
                            phase_reg <= PH_DECEL;
                    end
                    PH_DECEL: begin
                        if (dv_big || f_dn[FEED_W] || f_dn[FEED_W-1:0] < floor_reg) begin
                            feed_reg  <= floor_reg;
                            phase_reg <= PH_STOP;
                        end else begin
                            feed_reg <= f_dn[FEED_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // item latch, result and arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg     <= in_opcode;
            stp_reg    <= in_steps;
            len_in_reg <= in_path_length;
            fc_in_reg  <= in_cruise_feed;
            fs_in_reg  <= in_feed_start;
            fe_in_reg  <= in_feed_stop;
            up_in_reg  <= in_ramp_up;
            dn_in_reg  <= in_ramp_down;
            es_reg     <= in_endstops;
        end
        if (cmd.decode) begin
            pulses_reg  <= '0;
            delay_reg   <= '0;
            tick_ok_reg <= 1'b0;
            if (!op_reg) begin
                status_reg <= s_reject ? ST_REJECTED
                            : (s_best == '0) ? ST_FINISHED : ST_STARTED;
            end else if (!moving_tick) begin
                status_reg <= ST_IDLE;
            end else if (t_hit) begin
                status_reg <= ST_ABORT;
            end else begin
                pulses_reg  <= t_pulses;
                status_reg  <= (t_cnt >= total_reg) ? ST_FINISHED : ST_STEP;
                tick_ok_reg <= (t_cnt < total_reg);
            end
        end
        // low half of the reciprocal product, k is ready on the divider
        if (cmd.div_feed) begin
            k_reg   <= div_q;
            plo_reg <= 57'(feed_reg[21:3]) * 57'(RECIP_125);
        end
        // feed in mm per minute, zero taken as one
        if (cmd.feed_hi) f_reg <= (feed_q == '0) ? DIV_W'(1) : DIV_W'(feed_q);
        if (cmd.mul_dv) begin
            delay_reg <= (|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
            dv_reg    <= (DIV_W+17)'(accel_rate) *
                         (DIV_W+17)'((|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0]);
        end
    end

    assign stat.is_tick   = op_reg;
    assign stat.tick_done = (!op_reg) ? 1'b0 : (moving_tick && !t_hit && t_cnt < total_reg);
    assign stat.div_busy  = div_busy;

    assign res_status = status_reg;
    assign res_pulses = pulses_reg;
    always_comb begin
        res_dir = '0;
        for (int i = 0; i < NAX; i++) res_dir[i] = ~neg_reg[i];
    end
    assign res_delay = delay_reg;

    ap_delay_only_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && res_status != ST_STEP |-> res_delay == '0)
        else $error("delay on non-step result");
    ap_feed_needs_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_k |-> tick_ok_reg) else $error("division on non-step item");
    ap_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restarted while busy");

endmodule

@@ hdl/trapezoid_line_step_generator_core.sv @@
// ----------------------------------------------------------------------------
// trapezoid_line_step_generator_core
// Three-axis line stepper with trapezoidal feed profile.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata: steps, length, feeds, ramps, endstops
//   m_axis   | out       | tdata: status, pulses, directions, delay
//   cfg      | in        | accel_rate
//
// Start items and non-stepping ticks go from decode straight to the output
// state.
// A stepping tick runs two serial divisions on the shared divider and a
// reciprocal scale of the feed, low then high half, before its result is
// registered.
// Reset is synchronous active low; no clearing pass is needed.
// One item is in flight; a result waits in the output register while held.
// ----------------------------------------------------------------------------
module trapezoid_line_step_generator_core
    import tlsg_pkg::*;
#(
    parameter int AXES      = 3,
    parameter int STEP_BITS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // steps_x, steps_y, steps_z, path_length, cruise_feed, feed_start,
    // feed_stop, ramp_up_steps, ramp_down_steps, endstop_bits
    input  logic [215:0] s_tdata,
    input  logic         s_tuser,     // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, step_pulses, direction_bits, delay_us
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data
);

    logic [16:0] accel_reg;
    logic        mvalid_reg;
    logic [47:0] mdata_reg;
    cmd_t        cmd;
    stat_t       stat;
    logic [2:0]  r_status, r_pulses, r_dir;
    logic [31:0] r_delay;
    logic [AXES*STEP_BITS-1:0] steps_bus;

    // sign-extended axis steps
    always_comb begin
        steps_bus = '0;
        for (int i = 0; i < AXES; i++)
            if (i < 3)
                steps_bus[i*STEP_BITS +: STEP_BITS] =
                    STEP_BITS'($signed(s_tdata[i*24 +: 24]));
    end

    tlsg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_tvalid && s_tready),
        .out_free(!mvalid_reg || m_tready), .stat(stat),
        .in_ready(s_tready), .cmd(cmd)
    );

    tlsg_datapath #(.AXES(AXES), .STEP_BITS(STEP_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .accel_rate(accel_reg), .in_opcode(s_tuser), .in_steps(steps_bus),
        .in_path_length(s_tdata[95:72]), .in_cruise_feed(s_tdata[111:96]),
        .in_feed_start(s_tdata[127:112]), .in_feed_stop(s_tdata[143:128]),
        .in_ramp_up(s_tdata[167:144]), .in_ramp_down(s_tdata[191:168]),
        .in_endstops(s_tdata[194:192]),
        .res_status(r_status), .res_pulses(r_pulses), .res_dir(r_dir),
        .res_delay(r_delay)
    );

    // config register and output register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg  <= 17'd100;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) accel_reg <= cfg_data;
            if (cmd.emit) mvalid_reg <= 1'b1;
            else if (m_tready) mvalid_reg <= 1'b0;
        end
        if (cmd.emit) mdata_reg <= {7'd0, r_delay, r_dir, r_pulses, r_status};
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

@@ sim/trapezoid_line_step_generator_core_tb.sv @@
// ----------------------------------------------------------------------------
// trapezoid_line_step_generator_core_tb
// Drives start and tick transfers into the line step generator, predicts each
// response in a scoreboard that tracks the move state, and compares every
// field of every response. Sender bursts, receiver stalls and accel_rate
// changes between phases exercise the handshakes and the feed profile.
// ----------------------------------------------------------------------------
module trapezoid_line_step_generator_core_tb
    import tlsg_pkg::*;
();

    localparam int  CLK_HALF     = 5;
    localparam int  TARGET_ITEMS = 1900;
    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  SETTLE       = 300;
    localparam longint FEED_TOP  = (64'sd1 << 40) - 1;

    // expected response of one transfer
    typedef struct {
        status_t     status;
        bit [2:0]    pulses;
        bit [2:0]    dirs;
        bit [31:0]   delay;
    } motion_resp_t;

    // move state tracker and response checker
    class motion_scoreboard;
        int unsigned  accel;
        phase_t       ph;
        bit           moving;
        bit [23:0]    step_cnt, total, len, up, down;
        int           major;
        bit [23:0]    mag[3];
        bit           neg[3];
        bit [31:0]    err[3];
        longint       feed_now, feed_floor;
        bit [15:0]    cruise;
        bit [2:0]     last_es;
        motion_resp_t due[$];
        int           errors;

        function new();
            accel = 100;
            ph = PH_STOP;
            moving = 0;
            step_cnt = 0; total = 0; len = 0; up = 0; down = 0;
            major = 0;
            feed_now = 0; feed_floor = 0; cruise = 0; last_es = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = 0; neg[i] = 0; err[i] = 0;
            end
            errors = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        function longint tick_delay();
            longint k, f, d;
            k = (100 * longint'(len)) / longint'(total);
            f = feed_now / 1000;
            if (f == 0) f = 1;
            d = (k * 6000) / f;
            return (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d;
        endfunction

        // predict the response to one accepted input transfer
        function void note_input(bit op, bit [215:0] d);
            motion_resp_t r;
            bit [2:0]     es;
            bit           bad;
            longint       s, dv, nf, cruise_end, dl;
            bit [2:0]     fresh;
            es = d[194:192];
            r.status = ST_IDLE;
            r.pulses = 0;
            r.delay = 0;
            bad = 0;
            if (!op) begin
                for (int i = 0; i < 3; i++) begin
                    s = longint'($signed(d[24*i +: 24]));
                    neg[i] = s < 0;
                    mag[i] = (s < 0) ? -s : s;
                    if (es[i] && neg[i]) bad = 1;
                end
                last_es = es;
                if (bad) begin
                    r.status = ST_REJECTED;
                end else begin
                    major = 0;
                    for (int i = 1; i < 3; i++)
                        if (mag[i] > mag[major]) major = i;
                    total = mag[major];
                    len = d[95:72];
                    cruise = d[111:96];
                    feed_now = longint'(d[127:112]) * 1000;
                    feed_floor = longint'(d[143:128]) * 1000;
                    up = d[167:144];
                    down = d[191:168];
                    if (total == 0) begin
                        moving = 0;
                        r.status = ST_FINISHED;
                    end else begin
                        ph = PH_ACCEL;
                        moving = 1;
                        step_cnt = 0;
                        r.status = ST_STARTED;
                    end
                end
            end else if (moving && step_cnt < total) begin
                fresh = es & ~last_es;
                for (int i = 0; i < 3; i++)
                    if (neg[i] && fresh[i]) bad = 1;
                if (bad) begin
                    moving = 0;
                    r.status = ST_ABORT;
                end else begin
                    last_es = es;
                    r.pulses[major] = 1'b1;
                    // bresenham on the minor axes
                    for (int i = 0; i < 3; i++) begin
                        if (i == major) continue;
                        err[i] = err[i] + 32'(mag[i]);
                        if (longint'($signed(err[i])) * 2 >= longint'(total)) begin
                            err[i] = err[i] - 32'(total);
                            r.pulses[i] = 1'b1;
                        end
                    end
                    step_cnt = step_cnt + 1;
                    if (step_cnt >= total) begin
                        moving = 0;
                        r.status = ST_FINISHED;
                    end else begin
                        cruise_end = longint'(total) - longint'(down);
                        dl = tick_delay();
                        r.delay = dl[31:0];
                        dv = (longint'(accel) * dl) / 16;
                        r.status = ST_STEP;
                        // trapezoid profile
                        case (ph)
                            PH_ACCEL: begin
                                if (step_cnt >= up) begin
                                    if (longint'(step_cnt) < cruise_end) begin
                                        ph = PH_CRUISE;
                                        feed_now = longint'(cruise) * 1000;
                                    end else begin
                                        ph = PH_DECEL;
                                    end
                                end else begin
                                    nf = feed_now + dv;
                                    feed_now = (nf > FEED_TOP) ? FEED_TOP : nf;
                                end
                            end
                            PH_CRUISE: begin
                                if (longint'(step_cnt) >= cruise_end) ph = PH_DECEL;
                            end
                            PH_DECEL: begin
                                nf = feed_now - dv;
                                if (nf < feed_floor) begin
                                    feed_now = feed_floor;
                                    ph = PH_STOP;
                                end else begin
                                    feed_now = nf;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            for (int i = 0; i < 3; i++) r.dirs[i] = !neg[i];
            due.push_back(r);
        endfunction

        // compare one accepted response with the oldest prediction
        task check_result(bit [47:0] t);
            motion_resp_t r;
            if (due.size() == 0) begin
                report($sformatf("unexpected response %h", t));
                return;
            end
            r = due.pop_front();
            if (t[2:0] != r.status)
                report($sformatf("status %0d, predicted %0d", t[2:0], r.status));
            if (t[5:3] != r.pulses)
                report($sformatf("step_pulses %b, predicted %b", t[5:3], r.pulses));
            if (t[8:6] != r.dirs)
                report($sformatf("direction_bits %b, predicted %b", t[8:6], r.dirs));
            if (t[40:9] != r.delay)
                report($sformatf("delay_us %0d, predicted %0d", t[40:9], r.delay));
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [215:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [16:0]  cfg_data;

    motion_scoreboard sb;
    int  cycles;
    int  sent;
    int  burst_left;
    bit  s_fire, m_fire, cfg_fire;
    bit  [215:0] s_snap;
    bit  s_op_snap;
    bit  [47:0] m_snap;
    bit  stall_mode;

    trapezoid_line_step_generator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // snapshot handshakes mid-cycle so the edge logic sees settled values
    always @(negedge aclk) begin
        s_fire   = s_tvalid && s_tready;
        m_fire   = m_tvalid && m_tready;
        cfg_fire = cfg_valid && cfg_ready;
        s_snap   = s_tdata;
        s_op_snap = s_tuser;
        m_snap   = m_tdata;
    end

    // scoreboard updates on each transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_fire) sb.note_input(s_op_snap, s_snap);
            if (m_fire) sb.check_result(m_snap);
        end
    end

    // receiver stall pattern: alternating free-running and choppy stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
            if (stall_mode)
                m_tready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 40) != 0 || 1'b0);
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one input transfer, with bursty gaps before it
    task automatic send_item(bit op, bit [215:0] d);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_fire);
        burst_left--;
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_accel(bit [16:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
        sb.accel = v;
    endtask

    function automatic bit [215:0] pack_start(int sx, int sy, int sz, bit [23:0] plen,
                                              bit [15:0] fc, bit [15:0] fs, bit [15:0] fe,
                                              bit [23:0] ru, bit [23:0] rd, bit [2:0] es);
        bit [215:0] d;
        d = '0;
        d[23:0] = sx[23:0];
        d[47:24] = sy[23:0];
        d[71:48] = sz[23:0];
        d[95:72] = plen;
        d[111:96] = fc;
        d[127:112] = fs;
        d[143:128] = fe;
        d[167:144] = ru;
        d[191:168] = rd;
        d[194:192] = es;
        return d;
    endfunction

    function automatic bit [215:0] pack_tick(bit [2:0] es);
        bit [215:0] d;
        d = '0;
        d[194:192] = es;
        return d;
    endfunction

    function automatic bit [215:0] noise_fields();
        bit [215:0] d;
        for (int i = 0; i < 6; i++) d[32*i +: 32] = $urandom;
        d[215:192] = 24'($urandom);
        d[215:195] = '0;
        return d;
    endfunction

    // one well-formed move with random content
    task automatic run_move(int n);
        int   sx, sy, sz, ticks;
        bit   [2:0] es;
        sx = $signed($urandom_range(0, 2*n)) - n;
        sy = $signed($urandom_range(0, 2*n)) - n;
        sz = $signed($urandom_range(0, 2*n)) - n;
        es = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b000;
        send_item(1'b0, pack_start(sx, sy, sz, 24'($urandom_range(1, 5000)),
                  16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
                  16'($urandom_range(1, 3000)), 24'($urandom_range(0, n)),
                  24'($urandom_range(0, n)), es));
        ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n + 1;
        for (int t = 0; t < ticks; t++) begin
            if ($urandom_range(0, 29) == 0) es = 3'($urandom);
            send_item(1'b1, pack_tick(es));
        end
    endtask

    initial begin
        bit [16:0] accel_set[4];
        sb = new();
        cycles = 0;
        sent = 0;
        burst_left = 0;
        stall_mode = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle tick, zero move, extremes, reject, abort, full move
        send_item(1'b1, pack_tick(3'b000));
        send_item(1'b0, pack_start(0, 0, 0, 24'd100, 16'd1, 16'd1, 16'd1, 0, 0, 3'b000));
        send_item(1'b0, pack_start(8388607, -8388608, 0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 3'b000));
        send_item(1'b1, pack_tick(3'b001));
        send_item(1'b1, pack_tick(3'b011));
        send_item(1'b0, pack_start(-8388608, 5, 8388607, 24'd1, 16'd0, 16'd0, 16'd0,
                  0, 0, 3'b000));
        send_item(1'b1, pack_tick(3'b000));
        send_item(1'b0, pack_start(-3, 2, 1, 24'd300, 16'd500, 16'd100, 16'd50,
                  1, 1, 3'b001));
        send_item(1'b0, pack_start(-4, 4, -4, 24'd300, 16'd500, 16'd100, 16'd50,
                  1, 1, 3'b010));
        send_item(1'b1, pack_tick(3'b010));
        send_item(1'b1, pack_tick(3'b100));
        send_item(1'b1, pack_tick(3'b000));
        send_item(1'b0, pack_start(6, -3, 2, 24'd1000, 16'd2000, 16'd100, 16'd10,
                  2, 2, 3'b111));
        for (int i = 0; i < 7; i++) send_item(1'b1, pack_tick(3'b111));
        send_item(1'b0, pack_start(1, 0, 0, 24'd0, 16'd1, 16'd1, 16'd1, 0, 0, 3'b000));
        send_item(1'b1, pack_tick(3'b000));
        send_item(1'b1, pack_tick(3'b000));
        drain();

        // random phases across accel_rate settings
        accel_set[0] = 17'd100000;
        accel_set[1] = 17'd0;
        accel_set[2] = 17'($urandom_range(1, 100000));
        accel_set[3] = 17'd100;
        for (int p = 0; p < 4; p++) begin
            write_accel(accel_set[p]);
            while (sent < 25 + (TARGET_ITEMS * (p + 1)) / 4) begin
                case ($urandom_range(0, 19))
                    0: begin
                        send_item(1'b0, noise_fields());
                        repeat ($urandom_range(0, 3)) send_item(1'b1, noise_fields());
                    end
                    1: send_item(1'b1, noise_fields());
                    2: run_move($urandom_range(1, 200));
                    default: run_move($urandom_range(1, 24));
                endcase
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
